[rtl/tlrf_pkg.sv]
// shared types, constants and helpers for the timestamp line range filter
package tlrf_pkg;

	localparam int TIME_BITS   = 38;
	// widest civil time the converter produces (year 9999 fits below 2^38)
	localparam int CIVIL_BITS  = 38;
	localparam int CMP_BITS    = (TIME_BITS > CIVIL_BITS) ? TIME_BITS : CIVIL_BITS;
	localparam logic [TIME_BITS-1:0] TIME_ONES = '1;

	localparam int FIELD_BITS  = 14;
	localparam logic [FIELD_BITS-1:0] FIELD_MAX = 14'd16383;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// ascii codes
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [FIELD_BITS-1:0] YEAR_MIN = 14'd1970;
	localparam logic [FIELD_BITS-1:0] YEAR_MAX = 14'd9999;

	// reciprocal multipliers for the constant divides
	localparam logic [12:0] DIV400_MUL   = 13'd5243;
	localparam int          DIV400_SHIFT = 21;
	localparam logic [5:0]  DIV100_MUL   = 6'd41;
	localparam int          DIV100_SHIFT = 12;
	localparam logic [19:0] EPOCH_DAYS   = 20'd719468;

	// configuration register indexes
	typedef logic [0:0] cfg_index_t;
	localparam cfg_index_t CFG_START_TIME = 1'b0;
	localparam cfg_index_t CFG_END_TIME   = 1'b1;

	typedef enum logic [3:0] {
		PH_SEEK,
		PH_YEAR,
		PH_MON0,
		PH_MON,
		PH_DAY0,
		PH_DAY,
		PH_HOUR0,
		PH_HOUR,
		PH_MIN0,
		PH_MIN,
		PH_SEC0,
		PH_SEC,
		PH_TAIL
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ERA,
		BK_YOE,
		BK_PARTS,
		BK_DAYS,
		BK_SECS,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        valid;
	} line_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// day of the march-based year on which a month starts
	function automatic logic [8:0] day_offset(input logic [3:0] month);
		logic [8:0] off;
		case (month)
			4'd3:    off = 9'd0;
			4'd4:    off = 9'd31;
			4'd5:    off = 9'd61;
			4'd6:    off = 9'd92;
			4'd7:    off = 9'd122;
			4'd8:    off = 9'd153;
			4'd9:    off = 9'd184;
			4'd10:   off = 9'd214;
			4'd11:   off = 9'd245;
			4'd12:   off = 9'd275;
			4'd1:    off = 9'd306;
			4'd2:    off = 9'd337;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

endpackage

[rtl/tlrf_char_if.sv]
// byte stream channel
interface tlrf_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

[rtl/tlrf_result_if.sv]
// per-line result channel
interface tlrf_result_if;
	import tlrf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] line_time;
	logic                 time_valid;
	logic                 keep_line;
	logic                 end_reached;

	modport source (output valid, output line_time, output time_valid,
		output keep_line, output end_reached, input ready);
	modport sink (input valid, input line_time, input time_valid,
		input keep_line, input end_reached, output ready);
endinterface

[rtl/timestamp_line_range_filter.sv]
// top level: configuration registers, parser, record queue and time converter
// one byte accepted per cycle while the four-entry record queue has room
// a result is registered in the done state after the record of its line is popped
// one line at a time passes the sequencer states, which bounds the line rate
// reset clears the parser, queue, sequencer, stop flag and both bounds to zero
// lines that arrive after a line passes the end bound give no result until reset
module timestamp_line_range_filter (
	input  logic                           clk,
	input  logic                           arst_n,
	tlrf_char_if.sink                      chars,
	tlrf_result_if.source                  results,
	input  logic                           cfg_wr_en,
	input  tlrf_pkg::cfg_index_t           cfg_index,
	input  logic [tlrf_pkg::TIME_BITS-1:0] cfg_wdata
);
	import tlrf_pkg::*;

	logic [TIME_BITS-1:0] start_time_q;
	logic [TIME_BITS-1:0] end_time_q;

	logic        push;
	line_rec_t   push_rec;
	logic        pop;
	line_rec_t   head;
	queue_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= '0;
			end_time_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_START_TIME: start_time_q <= cfg_wdata;
				CFG_END_TIME:   end_time_q   <= cfg_wdata;
				default:        start_time_q <= start_time_q;
			endcase
		end
	end

	tlrf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.q_stat   (q_stat),
		.push     (push),
		.push_rec (push_rec)
	);

	tlrf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	tlrf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head       (head),
		.pop        (pop),
		.start_time (start_time_q),
		.end_time   (end_time_q),
		.results    (results)
	);

endmodule

[rtl/tlrf_front.sv]
// byte parser: parses the stamp fields, pushes one record per line that has a digit
module tlrf_front (
	input  logic                   clk,
	input  logic                   arst_n,
	tlrf_char_if.sink              chars,
	input  tlrf_pkg::queue_stat_t  q_stat,
	output logic                   push,
	output tlrf_pkg::line_rec_t    push_rec
);
	import tlrf_pkg::*;

	phase_t                phase_q, phase_n;
	logic [FIELD_BITS-1:0] field_q, field_n;
	logic [13:0]           year_q, year_n;
	logic [3:0]            month_q, month_n;
	logic [4:0]            day_q, day_n;
	logic [4:0]            hour_q, hour_n;
	logic [5:0]            minute_q, minute_n;
	logic [5:0]            second_q, second_n;
	logic                  bad_q, bad_n;
	logic                  in_line_q, in_line_n;

	logic                  accept;
	logic                  is_digit;
	logic                  is_eol;
	logic [17:0]           take_sum;
	logic [FIELD_BITS-1:0] take_val;
	logic                  field_bad;
	logic                  sep_ok;
	logic                  do_close;

	assign chars.ready = !q_stat.full;
	assign accept      = chars.valid && chars.ready;
	assign is_digit    = (chars.char_in >= CH_ZERO) && (chars.char_in <= CH_NINE);
	assign is_eol      = (chars.char_in == CH_LF) || (chars.char_in == CH_CR);

	assign take_sum = 18'(field_q) * 18'd10 + 18'(chars.char_in[3:0]);
	assign take_val = (take_sum > 18'(FIELD_MAX)) ? FIELD_MAX : take_sum[FIELD_BITS-1:0];

	always_comb begin
		case (phase_q)
			PH_YEAR: field_bad = (field_q < YEAR_MIN) || (field_q > YEAR_MAX);
			PH_MON:  field_bad = (field_q < 14'd1) || (field_q > 14'd12);
			PH_DAY:  field_bad = (field_q < 14'd1) || (field_q > 14'd31);
			PH_HOUR: field_bad = field_q > 14'd23;
			PH_MIN:  field_bad = field_q > 14'd59;
			default: field_bad = field_q > 14'd60;
		endcase
	end

	assign sep_ok = ((phase_q == PH_YEAR) && (chars.char_in == CH_DASH))
		|| ((phase_q == PH_MON) && (chars.char_in == CH_DASH))
		|| ((phase_q == PH_DAY) && (chars.char_in == CH_T))
		|| ((phase_q == PH_HOUR) && (chars.char_in == CH_COLON))
		|| ((phase_q == PH_MIN) && (chars.char_in == CH_COLON));

	// next state
	always_comb begin
		phase_n   = phase_q;
		field_n   = field_q;
		year_n    = year_q;
		month_n   = month_q;
		day_n     = day_q;
		hour_n    = hour_q;
		minute_n  = minute_q;
		second_n  = second_q;
		bad_n     = bad_q;
		in_line_n = in_line_q;
		do_close  = 1'b0;
		if (accept) begin
			if (!in_line_q) begin
				if (is_digit) begin
					in_line_n = 1'b1;
					phase_n   = PH_YEAR;
					field_n   = FIELD_BITS'(chars.char_in[3:0]);
				end
			end else if (!is_eol) begin
				if (phase_q >= PH_TAIL) begin
					phase_n = phase_q;
				end else if (is_digit) begin
					field_n = take_val;
					// first digit of a field moves on to its digit run
					if (!phase_q[0])
						phase_n = phase_t'(phase_q + 4'd1);
				end else if (phase_q == PH_SEC) begin
					do_close = 1'b1;
					phase_n  = PH_TAIL;
				end else if (sep_ok) begin
					do_close = 1'b1;
					phase_n  = phase_t'(phase_q + 4'd1);
				end else begin
					bad_n   = 1'b1;
					phase_n = PH_TAIL;
				end
			end else begin
				phase_n   = PH_SEEK;
				field_n   = '0;
				bad_n     = 1'b0;
				in_line_n = 1'b0;
			end
		end
		if (do_close) begin
			field_n = '0;
			if (field_bad) begin
				bad_n = 1'b1;
			end else begin
				case (phase_q)
					PH_YEAR: year_n   = field_q;
					PH_MON:  month_n  = field_q[3:0];
					PH_DAY:  day_n    = field_q[4:0];
					PH_HOUR: hour_n   = field_q[4:0];
					PH_MIN:  minute_n = field_q[5:0];
					default: second_n = field_q[5:0];
				endcase
			end
		end
	end

	// outputs: the record of a line goes out on its end-of-line byte
	always_comb begin
		push            = accept && in_line_q && is_eol;
		push_rec.year   = year_q;
		push_rec.month  = month_q;
		push_rec.day    = day_q;
		push_rec.hour   = hour_q;
		push_rec.minute = minute_q;
		push_rec.second = (phase_q == PH_SEC) ? field_q[5:0] : second_q;
		push_rec.valid  = !bad_q && ((phase_q == PH_TAIL)
			|| ((phase_q == PH_SEC) && (field_q <= 14'd60)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SEEK;
			field_q   <= '0;
			bad_q     <= 1'b0;
			in_line_q <= 1'b0;
		end else begin
			phase_q   <= phase_n;
			field_q   <= field_n;
			bad_q     <= bad_n;
			in_line_q <= in_line_n;
		end
	end

	always_ff @(posedge clk) begin
		year_q   <= year_n;
		month_q  <= month_n;
		day_q    <= day_n;
		hour_q   <= hour_n;
		minute_q <= minute_n;
		second_q <= second_n;
	end

endmodule

[rtl/tlrf_queue.sv]
// short record queue between the parser and the time converter
module tlrf_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  tlrf_pkg::line_rec_t    push_rec,
	input  logic                   pop,
	output tlrf_pkg::line_rec_t    head,
	output tlrf_pkg::queue_stat_t  stat
);
	import tlrf_pkg::*;

	line_rec_t           ent_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign head       = ent_q[rd_ptr_q];
	assign stat.full  = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign stat.empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_rec;
	end

endmodule

[rtl/tlrf_back.sv]
// time converter: days-from-civil sequencer, range compares and result register
module tlrf_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tlrf_pkg::queue_stat_t          q_stat,
	input  tlrf_pkg::line_rec_t            head,
	output logic                           pop,
	input  logic [tlrf_pkg::TIME_BITS-1:0] start_time,
	input  logic [tlrf_pkg::TIME_BITS-1:0] end_time,
	tlrf_result_if.source                  results
);
	import tlrf_pkg::*;

	back_state_t          state_q, state_n;
	logic                 load_out;

	line_rec_t            rec_q;
	logic [13:0]          y_q;
	logic [5:0]           era_q;
	logic [8:0]           doy_q;
	logic [16:0]          hms_q;
	logic [8:0]           yoe_q;
	logic [17:0]          yoe365_q;
	logic [2:0]           cent_q;
	logic [6:0]           quad_q;
	logic [22:0]          era_days_q;
	logic [22:0]          days_q;
	logic [CIVIL_BITS-1:0] t_q;

	logic                 out_valid_q;
	logic                 stopped_q;
	logic [TIME_BITS-1:0] out_time_q;
	logic                 out_tvalid_q;
	logic                 out_keep_q;
	logic                 out_end_q;

	logic [13:0]          y_c;
	logic [26:0]          era_prod;
	logic [13:0]          yoe_wide;
	logic [14:0]          cent_prod;
	logic [39:0]          secs_prod;
	logic                 t_ok;
	logic [TIME_BITS-1:0] t_fin;
	logic                 endr;
	logic                 keep;

	// march-based year: jan and feb belong to the year before
	assign y_c      = rec_q.year - ((rec_q.month <= 4'd2) ? 14'd1 : 14'd0);
	assign era_prod = 27'(y_c) * 27'(DIV400_MUL);
	assign yoe_wide = y_q - 14'(era_q) * 14'd400;
	assign cent_prod = 15'(yoe_q) * 15'(DIV100_MUL);
	assign secs_prod = 40'(days_q) * 40'd86400 + 40'(hms_q);

	assign t_ok  = rec_q.valid && (CMP_BITS'(t_q) < CMP_BITS'(TIME_ONES));
	assign t_fin = t_ok ? TIME_BITS'(t_q) : TIME_ONES;
	assign endr  = (end_time != '0) && (t_fin > end_time);
	assign keep  = !endr && (start_time < t_fin);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE:  if (!q_stat.empty) state_n = BK_ERA;
			BK_ERA:   state_n = BK_YOE;
			BK_YOE:   state_n = BK_PARTS;
			BK_PARTS: state_n = BK_DAYS;
			BK_DAYS:  state_n = BK_SECS;
			BK_SECS:  state_n = BK_DONE;
			BK_DONE:  if (stopped_q || !out_valid_q || results.ready) state_n = BK_IDLE;
			default:  state_n = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop      = (state_q == BK_IDLE) && !q_stat.empty;
		load_out = (state_q == BK_DONE) && !stopped_q && (!out_valid_q || results.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			stopped_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
			// once a line passes the end bound every later line is dropped
			if (load_out && endr)
				stopped_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			rec_q <= head;
		if (state_q == BK_ERA) begin
			y_q   <= y_c;
			era_q <= era_prod[DIV400_SHIFT+5:DIV400_SHIFT];
			doy_q <= day_offset(rec_q.month) + 9'(rec_q.day) - 9'd1;
			hms_q <= 17'(rec_q.hour) * 17'd3600 + 17'(rec_q.minute) * 17'd60
				+ 17'(rec_q.second);
		end
		if (state_q == BK_YOE)
			yoe_q <= yoe_wide[8:0];
		if (state_q == BK_PARTS) begin
			yoe365_q   <= 18'(yoe_q) * 18'd365;
			cent_q     <= cent_prod[DIV100_SHIFT+2:DIV100_SHIFT];
			quad_q     <= yoe_q[8:2];
			era_days_q <= 23'(era_q) * 23'd146097;
		end
		if (state_q == BK_DAYS)
			days_q <= era_days_q + 23'(yoe365_q) + 23'(quad_q) - 23'(cent_q)
				+ 23'(doy_q) - 23'(EPOCH_DAYS);
		if (state_q == BK_SECS)
			t_q <= secs_prod[CIVIL_BITS-1:0];
		if (load_out) begin
			out_time_q   <= t_fin;
			out_tvalid_q <= t_ok;
			out_keep_q   <= keep;
			out_end_q    <= endr;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.line_time   = out_time_q;
	assign results.time_valid  = out_tvalid_q;
	assign results.keep_line   = out_keep_q;
	assign results.end_reached = out_end_q;

endmodule

[rtl/tlrf_checker.sv]
// port-level checks on the result channel, bound to the top level
module tlrf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [tlrf_pkg::TIME_BITS-1:0] line_time,
	input logic                           time_valid,
	input logic                           keep_line,
	input logic                           end_reached
);
	import tlrf_pkg::*;

	logic seen_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_end_q <= 1'b0;
		else if (out_valid && out_ready && end_reached)
			seen_end_q <= 1'b1;
	end

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_time)
			&& $stable(time_valid) && $stable(keep_line) && $stable(end_reached))
		else $error("result changed while stalled");

	a_valid_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && time_valid |-> line_time != TIME_ONES)
		else $error("valid time equals the invalid marker");

	a_invalid_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !time_valid |-> line_time == TIME_ONES)
		else $error("invalid stamp without all-ones time");

	a_keep_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(keep_line && end_reached))
		else $error("line both kept and past the end bound");

	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		seen_end_q |-> !out_valid)
		else $error("result after the end bound was reached");

endmodule

bind timestamp_line_range_filter tlrf_checker u_tlrf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.line_time   (results.line_time),
	.time_valid  (results.time_valid),
	.keep_line   (results.keep_line),
	.end_reached (results.end_reached)
);
